### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CC3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CC3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/cc3_pkg.sv
// ----------------------------------------------------------------------------
// cc3_pkg
// Shared types and constants of the 3D circumcenter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cc3_pkg;

  // bits of the second operand consumed per multiplier cell
  localparam int MUL_CHUNK = 8;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DEGEN = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

endpackage

`default_nettype wire

### sv/circumcenter_3d.sv
// ----------------------------------------------------------------------------
// circumcenter_3d
// Center of the circle through three points in space, saturated fixed point.
// ----------------------------------------------------------------------------
// Takes one point triple per cycle while stall_o is low and returns one
// center per triple, in order. The pipeline uses chunked multiplier cells
// for the squared norms, the scaled edge vectors and the final cross
// product, then a row of COORD_BITS+2 division cells, one quotient bit per
// cell. The quotient is rounded to nearest, ties away from zero. Collinear
// or coincident points return a zero center with status 1; a clamped
// coordinate gives status 2. The output register lets the pipeline keep
// accepting while a finished result waits.
`default_nettype none

module circumcenter_3d #(
  parameter int COORD_BITS = 24
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              valid_i,
  output logic                             stall_o,
  input  wire  logic signed [COORD_BITS-1:0] first_x_i,
  input  wire  logic signed [COORD_BITS-1:0] first_y_i,
  input  wire  logic signed [COORD_BITS-1:0] first_z_i,
  input  wire  logic signed [COORD_BITS-1:0] second_x_i,
  input  wire  logic signed [COORD_BITS-1:0] second_y_i,
  input  wire  logic signed [COORD_BITS-1:0] second_z_i,
  input  wire  logic signed [COORD_BITS-1:0] third_x_i,
  input  wire  logic signed [COORD_BITS-1:0] third_y_i,
  input  wire  logic signed [COORD_BITS-1:0] third_z_i,
  output logic                             valid_o,
  input  wire                              stall_i,
  output logic signed [COORD_BITS-1:0]     center_x_o,
  output logic signed [COORD_BITS-1:0]     center_y_o,
  output logic signed [COORD_BITS-1:0]     center_z_o,
  output logic [1:0]                       status_o
);
  import cc3_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int WV  = C + 1;          // edge vector
  localparam int WN  = 2 * C + 2;      // normal
  localparam int WS  = 2 * C + 3;      // squared edge length
  localparam int WW  = 3 * C + 4;      // scaled edge difference
  localparam int WC  = 5 * C + 6;      // numerator
  localparam int MW  = 5 * C + 5;      // numerator magnitude
  localparam int NW  = 4 * C + 4;      // |n|^2
  localparam int T   = C + 2;          // quotient bits before rounding
  localparam int LV  = (WV + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LN  = (WN + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int DP  = 7 + LV + LN + T;
  localparam int SW  = 3 * C + 7;

  localparam logic signed [C-1:0] MAXC = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] MINC = {1'b1, {(C-1){1'b0}}};

  logic          adv;
  logic [DP-1:0] vld_q;
  logic          out_vld_q;

  // hold only when the output is full and stalled and a result is arriving
  assign adv     = !(vld_q[DP-1] && out_vld_q && stall_i);
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DP-2:0], valid_i};
    end
  end

  // ---- stage 0: edge vectors
  logic signed [C-1:0]  a0_q [3];
  logic signed [WV-1:0] v1_0_q [3];
  logic signed [WV-1:0] v2_0_q [3];
  logic signed [C-1:0]  pa [3];
  logic signed [C-1:0]  pb [3];
  logic signed [C-1:0]  pc [3];

  assign pa[0] = first_x_i;  assign pa[1] = first_y_i;  assign pa[2] = first_z_i;
  assign pb[0] = second_x_i; assign pb[1] = second_y_i; assign pb[2] = second_z_i;
  assign pc[0] = third_x_i;  assign pc[1] = third_y_i;  assign pc[2] = third_z_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a0_q[k]   <= pa[k];
        v1_0_q[k] <= WV'(pb[k]) - WV'(pa[k]);
        v2_0_q[k] <= WV'(pc[k]) - WV'(pa[k]);
      end
    end
  end

  // ---- stage 1: normal partial products and squares
  logic signed [C-1:0]    a1_q [3];
  logic signed [WV-1:0]   v1_1_q [3];
  logic signed [WV-1:0]   v2_1_q [3];
  logic signed [WN-1:0]   np_a_q [3];
  logic signed [WN-1:0]   np_b_q [3];
  logic signed [WN-1:0]   sq1_q [3];
  logic signed [WN-1:0]   sq2_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_s1
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        a1_q[k]   <= a0_q[k];
        v1_1_q[k] <= v1_0_q[k];
        v2_1_q[k] <= v2_0_q[k];
        np_a_q[k] <= WN'(v1_0_q[I1]) * WN'(v2_0_q[I2]);
        np_b_q[k] <= WN'(v1_0_q[I2]) * WN'(v2_0_q[I1]);
        sq1_q[k]  <= WN'(v1_0_q[k]) * WN'(v1_0_q[k]);
        sq2_q[k]  <= WN'(v2_0_q[k]) * WN'(v2_0_q[k]);
      end
    end
  end

  // ---- stage 2: normal and squared edge lengths
  logic signed [C-1:0]  a2_q [3];
  logic signed [WV-1:0] v1_2_q [3];
  logic signed [WV-1:0] v2_2_q [3];
  logic signed [WN-1:0] n2_q [3];
  logic signed [WS-1:0] s1_q;
  logic signed [WS-1:0] s2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a2_q[k]   <= a1_q[k];
        v1_2_q[k] <= v1_1_q[k];
        v2_2_q[k] <= v2_1_q[k];
        n2_q[k]   <= np_a_q[k] - np_b_q[k];
      end
      s1_q <= WS'(sq1_q[0]) + WS'(sq1_q[1]) + WS'(sq1_q[2]);
      s2_q <= WS'(sq2_q[0]) + WS'(sq2_q[1]) + WS'(sq2_q[2]);
    end
  end

  // ---- |n|^2 and the degenerate flag
  logic signed [2*WN-1:0] nsq [3];
  logic [NW-1:0]          nn_q;
  logic                   degen_q;
  logic [NW-1:0]          nn_d_sum;

  for (genvar k = 0; k < 3; k++) begin : g_nn
    cc3_mul #(.WA(WN), .WB(WN)) u_mul (
      .clk_i(clk_i), .en_i(adv), .a_i(n2_q[k]), .b_i(n2_q[k]), .p_o(nsq[k])
    );
  end

  always_comb begin
    logic [NW-1:0] sum;
    sum = NW'(nsq[0]) + NW'(nsq[1]) + NW'(nsq[2]);
    nn_d_sum = sum;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nn_q    <= nn_d_sum;
      degen_q <= (nn_d_sum == '0);
    end
  end

  // ---- w = |v1|^2 v2 - |v2|^2 v1
  logic signed [WW-1:0] pw1 [3];
  logic signed [WW-1:0] pw2 [3];
  logic signed [WW-1:0] w_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_w
    cc3_mul #(.WA(WS), .WB(WV)) u_mul1 (
      .clk_i(clk_i), .en_i(adv), .a_i(s1_q), .b_i(v2_2_q[k]), .p_o(pw1[k])
    );
    cc3_mul #(.WA(WS), .WB(WV)) u_mul2 (
      .clk_i(clk_i), .en_i(adv), .a_i(s2_q), .b_i(v1_2_q[k]), .p_o(pw2[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= pw1[k] - pw2[k];
      end
    end
  end

  // ---- align n with w
  logic [3*WN-1:0]      n_flat;
  logic [3*WN-1:0]      nd_flat;
  logic signed [WN-1:0] nd [3];

  assign n_flat = {n2_q[2], n2_q[1], n2_q[0]};

  cc3_delay #(.W(3 * WN), .N(LV + 1)) u_ndly (
    .clk_i(clk_i), .en_i(adv), .d_i(n_flat), .q_o(nd_flat)
  );

  for (genvar k = 0; k < 3; k++) begin : g_nd
    assign nd[k] = $signed(nd_flat[k*WN +: WN]);
  end

  // ---- numerator c = w x n
  logic signed [WC-1:0] pcx_a [3];
  logic signed [WC-1:0] pcx_b [3];
  logic signed [WC-1:0] c_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_c
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    cc3_mul #(.WA(WW), .WB(WN)) u_mula (
      .clk_i(clk_i), .en_i(adv), .a_i(w_q[I1]), .b_i(nd[I2]), .p_o(pcx_a[k])
    );
    cc3_mul #(.WA(WW), .WB(WN)) u_mulb (
      .clk_i(clk_i), .en_i(adv), .a_i(w_q[I2]), .b_i(nd[I1]), .p_o(pcx_b[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= pcx_a[k] - pcx_b[k];
      end
    end
  end

  // ---- magnitude and sign
  logic [MW-1:0] mag_q [3];
  logic [2:0]    neg_q;

  always_ff @(posedge clk_i) begin
    logic [WC-1:0] absv;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        absv     = c_q[k][WC-1] ? WC'(-c_q[k]) : WC'(c_q[k]);
        mag_q[k] <= absv[MW-1:0];
        neg_q[k] <= c_q[k][WC-1];
      end
    end
  end

  // ---- side data aligned with the magnitude stage
  logic [NW:0]    nnd_flat;
  logic [3*C-1:0] a_flat;
  logic [3*C-1:0] ad_flat;

  cc3_delay #(.W(NW + 1), .N(LV + 2)) u_nndly (
    .clk_i(clk_i), .en_i(adv), .d_i({degen_q, nn_q}), .q_o(nnd_flat)
  );

  assign a_flat = {a2_q[2], a2_q[1], a2_q[0]};

  cc3_delay #(.W(3 * C), .N(LV + LN + 3)) u_adly (
    .clk_i(clk_i), .en_i(adv), .d_i(a_flat), .q_o(ad_flat)
  );

  // ---- division setup: split magnitude, detect quotient overflow
  logic [NW-1:0]          cell_nn   [T+1];
  logic [2:0][NW-1:0]     cell_rem  [T+1];
  logic [2:0][T-1:0]      cell_low  [T+1];
  logic [2:0][T-1:0]      cell_quo  [T+1];
  logic [SW-1:0]          cell_side [T+1];

  always_ff @(posedge clk_i) begin
    logic [2:0] ovf;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ovf[k]         = ({1'b0, mag_q[k][MW-1:T]} >= nnd_flat[NW-1:0]);
        cell_rem[0][k] <= NW'(mag_q[k][MW-1:T]);
        cell_low[0][k] <= mag_q[k][T-1:0];
      end
      cell_nn[0]   <= nnd_flat[NW-1:0];
      cell_quo[0]  <= '0;
      cell_side[0] <= {ad_flat, nnd_flat[NW], neg_q, ovf};
    end
  end

  for (genvar j = 0; j < T; j++) begin : g_div
    cc3_div_cell #(.NW(NW), .T(T), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .nn_i   (cell_nn[j]),
      .rem_i  (cell_rem[j]),
      .low_i  (cell_low[j]),
      .quo_i  (cell_quo[j]),
      .side_i (cell_side[j]),
      .nn_o   (cell_nn[j+1]),
      .rem_o  (cell_rem[j+1]),
      .low_o  (cell_low[j+1]),
      .quo_o  (cell_quo[j+1]),
      .side_o (cell_side[j+1])
    );
  end

  // ---- rounding, offset, clamp
  logic [2:0][C-1:0] fa;
  logic              fdegen;
  logic [2:0]        fneg;
  logic [2:0]        fovf;
  logic [2:0][C-1:0] res;
  logic [2:0]        sat;
  status_e           status_d;

  assign {fa, fdegen, fneg, fovf} = cell_side[T];

  always_comb begin
    logic [T:0]          tp1;
    logic signed [C+2:0] sum;
    for (int k = 0; k < 3; k++) begin
      tp1 = {1'b0, cell_quo[T][k]} + {{T{1'b0}}, 1'b1};
      if (fneg[k]) begin
        sum = (C+3)'($signed(fa[k])) - $signed({1'b0, tp1[T:1]});
      end else begin
        sum = (C+3)'($signed(fa[k])) + $signed({1'b0, tp1[T:1]});
      end
      sat[k] = 1'b1;
      priority if (fovf[k]) begin
        res[k] = fneg[k] ? MINC : MAXC;
      end else if (sum > (C+3)'(MAXC)) begin
        res[k] = MAXC;
      end else if (sum < (C+3)'(MINC)) begin
        res[k] = MINC;
      end else begin
        res[k] = sum[C-1:0];
        sat[k] = 1'b0;
      end
    end
    priority if (fdegen) begin
      status_d = STATUS_DEGEN;
    end else if (|sat) begin
      status_d = STATUS_SAT;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // ---- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && vld_q[DP-1]) begin
      out_vld_q <= 1'b1;
    end else if (!stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[DP-1]) begin
      center_x_o <= fdegen ? '0 : $signed(res[0]);
      center_y_o <= fdegen ? '0 : $signed(res[1]);
      center_z_o <= fdegen ? '0 : $signed(res[2]);
      status_o   <= status_d;
    end
  end

  assign valid_o = out_vld_q;

  `include "assert_macros.svh"

  `CC3_ASSERT_NOW(a_stall_only_when_full, stall_o, out_vld_q && stall_i && vld_q[DP-1])
  `CC3_ASSERT_NEXT(a_result_lands, vld_q[DP-1] && !stall_o, valid_o)
  `CC3_ASSERT_NOW(a_degen_zero, valid_o && (status_o == STATUS_DEGEN),
                  (center_x_o == '0) && (center_y_o == '0) && (center_z_o == '0))

endmodule

`default_nettype wire

### sv/cc3_mul.sv
// ----------------------------------------------------------------------------
// cc3_mul
// Signed multiplier built as a row of cells; each cell folds one chunk of
// the second operand into the running product.
// ----------------------------------------------------------------------------
`default_nettype none

module cc3_mul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  logic signed [WA-1:0] a_i,
  input  wire  logic signed [WB-1:0] b_i,
  output logic signed [WA+WB-1:0]    p_o
);
  import cc3_pkg::*;

  localparam int NC  = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int WBP = NC * MUL_CHUNK;
  localparam int WP  = WA + WBP;

  logic signed [WA-1:0]  a_q   [NC-1];
  logic signed [WBP-1:0] b_q   [NC-1];
  logic signed [WP-1:0]  acc_q [NC];

  for (genvar j = 0; j < NC; j++) begin : g_cell
    logic signed [WA-1:0]          a_in;
    logic signed [WBP-1:0]         b_in;
    logic signed [WP-1:0]          acc_in;
    logic signed [MUL_CHUNK:0]     chunk;
    logic signed [WA+MUL_CHUNK:0]  pp;

    if (j == 0) begin : g_first
      assign a_in   = a_i;
      assign b_in   = WBP'(b_i);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[j-1];
      assign b_in   = b_q[j-1];
      assign acc_in = acc_q[j-1];
    end

    // top chunk carries the sign, the rest are unsigned digits
    if (j == NC - 1) begin : g_top
      assign chunk = $signed({b_in[WBP-1], b_in[j*MUL_CHUNK +: MUL_CHUNK]});
    end else begin : g_low
      assign chunk = $signed({1'b0, b_in[j*MUL_CHUNK +: MUL_CHUNK]});
    end

    assign pp = a_in * chunk;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j] <= acc_in + (WP'(pp) <<< (j * MUL_CHUNK));
      end
    end

    if (j < NC - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[j] <= a_in;
          b_q[j] <= b_in;
        end
      end
    end
  end

  assign p_o = $signed(acc_q[NC-1][WA+WB-1:0]);

endmodule

`default_nettype wire

### sv/cc3_delay.sv
// ----------------------------------------------------------------------------
// cc3_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cc3_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  wire           clk_i,
  input  wire           en_i,
  input  wire  [W-1:0]  d_i,
  output logic [W-1:0]  q_o
);
  logic [N-1:0][W-1:0] sr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q <= {sr_q[N-2:0], d_i};
    end
  end

  assign q_o = sr_q[N-1];

endmodule

`default_nettype wire

### sv/cc3_div_cell.sv
// ----------------------------------------------------------------------------
// cc3_div_cell
// One restoring-division step for three lanes sharing one divisor; passes
// remainder, remaining dividend bits, quotient and side data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cc3_div_cell #(
  parameter int NW = 16,
  parameter int T  = 8,
  parameter int SW = 4
) (
  input  wire                    clk_i,
  input  wire                    en_i,
  input  wire  [NW-1:0]          nn_i,
  input  wire  [2:0][NW-1:0]     rem_i,
  input  wire  [2:0][T-1:0]      low_i,
  input  wire  [2:0][T-1:0]      quo_i,
  input  wire  [SW-1:0]          side_i,
  output logic [NW-1:0]          nn_o,
  output logic [2:0][NW-1:0]     rem_o,
  output logic [2:0][T-1:0]      low_o,
  output logic [2:0][T-1:0]      quo_o,
  output logic [SW-1:0]          side_o
);
  logic [2:0][NW-1:0] rem_d;
  logic [2:0][T-1:0]  low_d;
  logic [2:0][T-1:0]  quo_d;

  always_comb begin
    logic [NW:0] r2;
    logic        ge;
    for (int k = 0; k < 3; k++) begin
      r2 = {rem_i[k], low_i[k][T-1]};
      ge = (r2 >= {1'b0, nn_i});
      // remainder stays below the divisor, so the top bit drops
      if (ge) begin
        r2 = r2 - {1'b0, nn_i};
      end
      rem_d[k] = r2[NW-1:0];
      low_d[k] = {low_i[k][T-2:0], 1'b0};
      quo_d[k] = {quo_i[k][T-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn_o   <= nn_i;
      rem_o  <= rem_d;
      low_o  <= low_d;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire
